// ===== rtl/core/gaps_pkg.sv =====
// Shared types, codes and constants of the grid path search block.
package gaps_pkg;

   localparam int COORD_W    = 9;
   localparam int G_W        = 23;
   localparam int SCORE_W    = 31;
   localparam int LEN_W      = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 12;

   localparam logic [G_W-1:0]     G_MAX          = 23'h7FFFFF;
   localparam logic [SCORE_W-1:0] SCORE_SENTINEL = 31'd999999900;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_BEGIN = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [2:0] RS_SEARCHING = 3'd0;
   localparam logic [2:0] RS_FOUND     = 3'd1;
   localparam logic [2:0] RS_NOPATH    = 3'd2;
   localparam logic [2:0] RS_ACCEPTED  = 3'd3;
   localparam logic [2:0] RS_ENTRY     = 3'd4;

   localparam logic [1:0] SS_IDLE   = 2'd0;
   localparam logic [1:0] SS_SEARCH = 2'd1;
   localparam logic [1:0] SS_FOUND  = 2'd2;
   localparam logic [1:0] SS_NOPATH = 2'd3;

   localparam logic [1:0] DIR_LEFT   = 2'd0;
   localparam logic [1:0] DIR_RIGHT  = 2'd1;
   localparam logic [1:0] DIR_TOP    = 2'd2;
   localparam logic [1:0] DIR_BOTTOM = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_W  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_H  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY = 3'd7;

   localparam logic [6:0]  GRID_W_RST  = 7'd64;
   localparam logic [6:0]  GRID_H_RST  = 7'd64;
   localparam logic [7:0]  WEIGHT_RST  = 8'd101;
   localparam logic [11:0] PENALTY_RST = 12'd999;

   typedef struct packed {
      logic [1:0]  op;
      logic [5:0]  tile_x;
      logic [5:0]  tile_y;
      logic [7:0]  tile_cost;
      logic        tile_solid;
      logic        tile_occupied;
      logic [11:0] path_index;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [LEN_W-1:0] path_length;
      logic [5:0]       path_x;
      logic [5:0]       path_y;
   } rsp_type;

   typedef struct packed {
      logic       capture;
      logic       clear_step;
      logic       load_tile;
      logic       begin_search;
      logic       set_nopath;
      logic       status_set;
      logic [2:0] status_code;
      logic       open_calc;
      logic       open_mul;
      logic       open_push;
      logic       scan_init;
      logic       scan_run;
      logic       pop_cap;
      logic       pop_move;
      logic       nb_first;
      logic       nb_load;
      logic       nb_next;
      logic       route_init;
      logic       walk_rd;
      logic       route_wr;
      logic       route_next;
      logic       route_fin;
      logic       path_cap;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       clear_last;
      logic [1:0] sstate;
      logic       count_zero;
      logic       open_skip;
      logic       scan_done;
      logic       is_goal;
      logic       nb_ok;
      logic       nb_last;
      logic       route_end;
      logic       rsp_free;
      logic [1:0] op;
   } sts_type;

endpackage

// ===== rtl/core/gaps_ctrl.sv =====
// Sequencing state machine of the grid path search block.
module gaps_ctrl
   import gaps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_DECODE    = 5'd2;
   localparam logic [4:0] S_OPEN_RD   = 5'd3;
   localparam logic [4:0] S_OPEN_CHK  = 5'd4;
   localparam logic [4:0] S_OPEN_MUL  = 5'd5;
   localparam logic [4:0] S_OPEN_PUSH = 5'd6;
   localparam logic [4:0] S_SCAN      = 5'd7;
   localparam logic [4:0] S_POP_SEL   = 5'd8;
   localparam logic [4:0] S_POP_LAST  = 5'd9;
   localparam logic [4:0] S_POP_MOVE  = 5'd10;
   localparam logic [4:0] S_GOAL      = 5'd11;
   localparam logic [4:0] S_NB_SEL    = 5'd12;
   localparam logic [4:0] S_ROUTE_WR  = 5'd13;
   localparam logic [4:0] S_ROUTE_NX  = 5'd14;
   localparam logic [4:0] S_PATH_CAP  = 5'd15;
   localparam logic [4:0] S_FINISH    = 5'd16;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic [4:0] after_open;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      if ((sts.op == OP_BEGIN) || sts.nb_last) begin
         after_open = S_FINISH;
      end else begin
         after_open = S_NB_SEL;
      end
   end

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.status_set = 1'b1;
            unique case (sts.op)
               OP_LOAD: begin
                  cmd.load_tile   = 1'b1;
                  cmd.status_code = RS_ACCEPTED;
                  state_in        = S_FINISH;
               end
               OP_BEGIN: begin
                  cmd.begin_search = 1'b1;
                  cmd.status_code  = RS_ACCEPTED;
                  state_in         = S_OPEN_RD;
               end
               OP_STEP: begin
                  if (sts.sstate == SS_FOUND) begin
                     cmd.status_code = RS_FOUND;
                     state_in        = S_FINISH;
                  end else if ((sts.sstate != SS_SEARCH) || sts.count_zero) begin
                     cmd.set_nopath  = 1'b1;
                     cmd.status_code = RS_NOPATH;
                     state_in        = S_FINISH;
                  end else begin
                     cmd.scan_init   = 1'b1;
                     cmd.status_code = RS_SEARCHING;
                     state_in        = S_SCAN;
                  end
               end
               default: begin
                  cmd.status_code = RS_ENTRY;
                  state_in        = S_PATH_CAP;
               end
            endcase
         end
         S_OPEN_RD: begin
            state_in = S_OPEN_CHK;
         end
         S_OPEN_CHK: begin
            if (sts.open_skip) begin
               cmd.nb_next = (after_open == S_NB_SEL);
               state_in    = after_open;
            end else begin
               cmd.open_calc = 1'b1;
               state_in      = S_OPEN_MUL;
            end
         end
         S_OPEN_MUL: begin
            cmd.open_mul = 1'b1;
            state_in     = S_OPEN_PUSH;
         end
         S_OPEN_PUSH: begin
            cmd.open_push = 1'b1;
            cmd.nb_next   = (after_open == S_NB_SEL);
            state_in      = after_open;
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_POP_SEL;
            end else begin
               cmd.scan_run = 1'b1;
            end
         end
         S_POP_SEL: begin
            state_in = S_POP_LAST;
         end
         S_POP_LAST: begin
            cmd.pop_cap = 1'b1;
            state_in    = S_POP_MOVE;
         end
         S_POP_MOVE: begin
            cmd.pop_move = 1'b1;
            state_in     = S_GOAL;
         end
         S_GOAL: begin
            if (sts.is_goal) begin
               cmd.route_init = 1'b1;
               state_in       = S_ROUTE_WR;
            end else begin
               cmd.nb_first = 1'b1;
               state_in     = S_NB_SEL;
            end
         end
         S_NB_SEL: begin
            if (sts.nb_ok) begin
               cmd.nb_load = 1'b1;
               state_in    = S_OPEN_RD;
            end else if (sts.nb_last) begin
               state_in = S_FINISH;
            end else begin
               cmd.nb_next = 1'b1;
            end
         end
         S_ROUTE_WR: begin
            cmd.walk_rd  = 1'b1;
            cmd.route_wr = 1'b1;
            state_in     = S_ROUTE_NX;
         end
         S_ROUTE_NX: begin
            if (sts.route_end) begin
               cmd.route_fin   = 1'b1;
               cmd.status_set  = 1'b1;
               cmd.status_code = RS_FOUND;
               state_in        = S_FINISH;
            end else begin
               cmd.route_next = 1'b1;
               state_in       = S_ROUTE_WR;
            end
         end
         S_PATH_CAP: begin
            cmd.path_cap = 1'b1;
            state_in     = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/gaps_dp.sv =====
// Datapath of the grid path search block: tile map, open list, route store and arithmetic.
module gaps_dp
   import gaps_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int STAMP_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  cmd_type               cmd,
   output sts_type               sts
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int AW     = XW + YW;
   localparam int DEPTH  = 1 << AW;
   localparam int NCELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int CNT_W  = AW + 1;
   localparam int IW     = (CNT_W > 12) ? CNT_W : 12;
   localparam int H_W    = COORD_W + 1;
   localparam int PROD_W = 8 + H_W;
   localparam int HG_W   = G_W + 7;

   function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                  input logic [COORD_W-1:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

   logic [7:0]  cost_mem  [DEPTH];
   logic [1:0]  flag_mem  [DEPTH];
   logic [STAMP_BITS-1:0] stamp_mem [DEPTH];
   logic [AW:0] par_mem   [DEPTH];
   logic [AW-1:0]      ocell_mem [DEPTH];
   logic [G_W-1:0]     og_mem    [DEPTH];
   logic [SCORE_W-1:0] osc_mem   [DEPTH];
   logic [AW-1:0]      route_mem [DEPTH];

   logic [6:0]  gw_ff, gw_in, gh_ff, gh_in;
   logic [5:0]  sx_ff, sx_in, sy_ff, sy_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [7:0]  hw_ff, hw_in;
   logic [11:0] pen_ff, pen_in;
   logic [AW-1:0] sweep_ff, sweep_in;
   logic [STAMP_BITS-1:0] stamp_ff, stamp_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] route_len_ff, route_len_in;
   logic [1:0]  sstate_ff, sstate_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        cmpv_ff, cmpv_in;
   logic [CNT_W-1:0] scan_rd_ff, scan_rd_in;

   req_type item_ff, item_in;
   rsp_type rsp_ff, rsp_in;
   logic [2:0]  res_ff, res_in;
   logic [AW-1:0] cmpi_ff, cmpi_in, sel_ff, sel_in;
   logic [SCORE_W-1:0] best_ff, best_in;
   logic [AW-1:0] cur_ff, cur_in, nb_ff, nb_in, walk_ff, walk_in;
   logic [G_W-1:0] curg_ff, curg_in, base_g_ff, base_g_in, g_ff, g_in;
   logic [AW:0]  par_src_ff, par_src_in;
   logic         chk_ff, chk_in;
   logic [H_W-1:0] h_ff, h_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [HG_W-1:0] hg_ff, hg_in;
   logic [1:0]  dir_ff, dir_in;
   logic [CNT_W-1:0] route_n_ff, route_n_in;
   logic [5:0]  px_ff, px_in, py_ff, py_in;

   logic [7:0]  cost_q;
   logic [1:0]  flag_q;
   logic [STAMP_BITS-1:0] stamp_q;
   logic [AW:0] par_q;
   logic [AW-1:0] ocell_q;
   logic [G_W-1:0] og_q;
   logic [SCORE_W-1:0] osc_q;
   logic [AW-1:0] route_q;

   logic [COORD_W-1:0] effw, effh, gw_ext, gh_ext;
   logic [COORD_W-1:0] sx_ext, sy_ext, sx_c, sy_c;
   logic [COORD_W-1:0] tx_ext, ty_ext;
   logic [COORD_W-1:0] cx_ext, cy_ext, nbx_ext, nby_ext;
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic          load_ok;
   logic [AW-1:0] load_addr;
   logic [AW-1:0] cell_raddr;
   logic          stamp_we;
   logic [AW-1:0] stamp_waddr;
   logic [STAMP_BITS-1:0] stamp_wdata;
   logic [STAMP_BITS-1:0] stamp_next;
   logic          open_we;
   logic [AW-1:0] open_waddr, open_raddr, last_idx;
   logic [AW-1:0] open_wcell;
   logic [G_W-1:0] open_wg;
   logic [SCORE_W-1:0] open_wscore;
   logic [G_W:0]  g_sum;
   logic [11:0]   pen_use;
   logic          nb_ok;
   logic [AW-1:0] nb_addr;
   logic          path_ok;
   logic [AW-1:0] path_raddr;

   assign gw_ext = COORD_W'(gw_ff);
   assign gh_ext = COORD_W'(gh_ff);
   assign effw = (gw_ff == 7'd0) ? COORD_W'(1) :
                 ((gw_ext > COORD_W'(MAX_WIDTH)) ? COORD_W'(MAX_WIDTH) : gw_ext);
   assign effh = (gh_ff == 7'd0) ? COORD_W'(1) :
                 ((gh_ext > COORD_W'(MAX_HEIGHT)) ? COORD_W'(MAX_HEIGHT) : gh_ext);
   assign sx_ext = COORD_W'(sx_ff);
   assign sy_ext = COORD_W'(sy_ff);
   assign sx_c = (sx_ext >= effw) ? (effw - COORD_W'(1)) : sx_ext;
   assign sy_c = (sy_ext >= effh) ? (effh - COORD_W'(1)) : sy_ext;

   assign tx_ext = COORD_W'(item_ff.tile_x);
   assign ty_ext = COORD_W'(item_ff.tile_y);
   assign load_ok = (tx_ext < COORD_W'(MAX_WIDTH)) && (ty_ext < COORD_W'(MAX_HEIGHT));
   assign load_addr = {YW'(ty_ext), XW'(tx_ext)};

   assign cx = cur_ff[XW-1:0];
   assign cy = cur_ff[AW-1:XW];
   assign cx_ext = COORD_W'(cx);
   assign cy_ext = COORD_W'(cy);
   assign nbx_ext = COORD_W'(nb_ff[XW-1:0]);
   assign nby_ext = COORD_W'(nb_ff[AW-1:XW]);

   assign cell_raddr = cmd.walk_rd ? walk_ff : nb_ff;
   assign stamp_next = ((stamp_ff + STAMP_BITS'(1)) == '0) ? STAMP_BITS'(1) :
                       (stamp_ff + STAMP_BITS'(1));
   assign stamp_we    = cmd.clear_step || cmd.open_calc;
   assign stamp_waddr = cmd.clear_step ? sweep_ff : nb_ff;
   assign stamp_wdata = cmd.clear_step ? '0 : stamp_ff;

   assign last_idx    = AW'(count_ff - CNT_W'(1));
   assign open_raddr  = cmd.scan_run ? scan_rd_ff[AW-1:0] : (cmd.pop_cap ? last_idx : sel_ff);
   assign open_we     = (cmd.open_push && (count_ff < CNT_W'(NCELLS))) || cmd.pop_move;
   assign open_waddr  = cmd.open_push ? count_ff[AW-1:0] : sel_ff;
   assign open_wcell  = cmd.open_push ? nb_ff : ocell_q;
   assign open_wg     = cmd.open_push ? g_ff : og_q;
   assign open_wscore = cmd.open_push ? (SCORE_W'(prod_ff) + SCORE_W'(hg_ff)) : osc_q;

   assign pen_use = flag_q[1] ? pen_ff : 12'd0;
   assign g_sum   = (G_W+1)'(base_g_ff) + (G_W+1)'(cost_q) + (G_W+1)'(pen_use);

   assign path_ok    = (sstate_ff == SS_FOUND) &&
                       (IW'(item_ff.path_index) < IW'(route_len_ff));
   assign path_raddr = AW'(item_ff.path_index);

   always_comb begin
      nb_ok   = 1'b0;
      nb_addr = cur_ff;
      case (dir_ff)
         DIR_LEFT: begin
            nb_ok   = (cx != '0);
            nb_addr = {cy, cx - XW'(1)};
         end
         DIR_RIGHT: begin
            nb_ok   = ((cx_ext + COORD_W'(1)) < effw);
            nb_addr = {cy, cx + XW'(1)};
         end
         DIR_TOP: begin
            nb_ok   = ((cy_ext + COORD_W'(1)) < effh);
            nb_addr = {cy + YW'(1), cx};
         end
         default: begin
            nb_ok   = (cy != '0);
            nb_addr = {cy - YW'(1), cx};
         end
      endcase
   end

   always_comb begin
      gw_in = gw_ff; gh_in = gh_ff; sx_in = sx_ff; sy_in = sy_ff;
      gx_in = gx_ff; gy_in = gy_ff; hw_in = hw_ff; pen_in = pen_ff;
      sweep_in = sweep_ff; stamp_in = stamp_ff; count_in = count_ff;
      route_len_in = route_len_ff; sstate_in = sstate_ff;
      cmpv_in = cmpv_ff; scan_rd_in = scan_rd_ff;
      item_in = item_ff; rsp_in = rsp_ff; res_in = res_ff;
      cmpi_in = cmpi_ff; sel_in = sel_ff; best_in = best_ff;
      cur_in = cur_ff; nb_in = nb_ff; walk_in = walk_ff;
      curg_in = curg_ff; base_g_in = base_g_ff; g_in = g_ff;
      par_src_in = par_src_ff; chk_in = chk_ff; h_in = h_ff;
      prod_in = prod_ff; hg_in = hg_ff; dir_in = dir_ff;
      route_n_in = route_n_ff; px_in = px_ff; py_in = py_ff;

      if (csr_wr_en) begin
         unique case (csr_idx)
            CSR_GRID_W:  gw_in  = csr_wdata[6:0];
            CSR_GRID_H:  gh_in  = csr_wdata[6:0];
            CSR_START_X: sx_in  = csr_wdata[5:0];
            CSR_START_Y: sy_in  = csr_wdata[5:0];
            CSR_GOAL_X:  gx_in  = csr_wdata[5:0];
            CSR_GOAL_Y:  gy_in  = csr_wdata[5:0];
            CSR_WEIGHT:  hw_in  = csr_wdata[7:0];
            CSR_PENALTY: pen_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.clear_step) begin
         sweep_in = sweep_ff + AW'(1);
      end
      if (cmd.capture) begin
         item_in = req_data;
         px_in   = '0;
         py_in   = '0;
      end
      if (cmd.status_set) begin
         res_in = cmd.status_code;
      end
      if (cmd.set_nopath) begin
         sstate_in = SS_NOPATH;
      end
      if (cmd.begin_search) begin
         stamp_in     = stamp_next;
         count_in     = '0;
         route_len_in = '0;
         sstate_in    = SS_SEARCH;
         nb_in        = {YW'(sy_c), XW'(sx_c)};
         par_src_in   = {1'b1, AW'(0)};
         base_g_in    = '0;
         chk_in       = 1'b0;
      end
      if (cmd.nb_first) begin
         dir_in = DIR_LEFT;
      end
      if (cmd.nb_next) begin
         dir_in = dir_ff + 2'd1;
      end
      if (cmd.nb_load) begin
         nb_in      = nb_addr;
         par_src_in = {1'b0, cur_ff};
         base_g_in  = curg_ff;
         chk_in     = 1'b1;
      end
      if (cmd.open_calc) begin
         g_in = (g_sum > (G_W+1)'(G_MAX)) ? G_MAX : g_sum[G_W-1:0];
         h_in = H_W'(absdiff(nbx_ext, COORD_W'(gx_ff))) +
                H_W'(absdiff(nby_ext, COORD_W'(gy_ff)));
      end
      if (cmd.open_mul) begin
         prod_in = PROD_W'(hw_ff) * PROD_W'(h_ff);
         hg_in   = HG_W'(g_ff) * HG_W'(100);
      end
      if (cmd.open_push && (count_ff < CNT_W'(NCELLS))) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.scan_init) begin
         scan_rd_in = '0;
         cmpv_in    = 1'b0;
         best_in    = SCORE_SENTINEL;
         sel_in     = '0;
      end
      if (cmd.scan_run) begin
         if (scan_rd_ff != count_ff) begin
            scan_rd_in = scan_rd_ff + CNT_W'(1);
            cmpv_in    = 1'b1;
            cmpi_in    = scan_rd_ff[AW-1:0];
         end else begin
            cmpv_in = 1'b0;
         end
         if (cmpv_ff && (osc_q < best_ff)) begin
            best_in = osc_q;
            sel_in  = cmpi_ff;
         end
      end
      if (cmd.pop_cap) begin
         cur_in  = ocell_q;
         curg_in = og_q;
      end
      if (cmd.pop_move) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (cmd.route_init) begin
         walk_in    = cur_ff;
         route_n_in = '0;
      end
      if (cmd.route_wr) begin
         route_n_in = route_n_ff + CNT_W'(1);
      end
      if (cmd.route_next) begin
         walk_in = par_q[AW-1:0];
      end
      if (cmd.route_fin) begin
         route_len_in = route_n_ff - CNT_W'(1);
         sstate_in    = SS_FOUND;
      end
      if (cmd.path_cap) begin
         px_in = path_ok ? 6'(route_q[XW-1:0]) : 6'd0;
         py_in = path_ok ? 6'(route_q[AW-1:XW]) : 6'd0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in.status      = res_ff;
         rsp_in.path_length = LEN_W'(route_len_ff);
         rsp_in.path_x      = px_ff;
         rsp_in.path_y      = py_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff        <= GRID_W_RST;
         gh_ff        <= GRID_H_RST;
         sx_ff        <= '0;
         sy_ff        <= '0;
         gx_ff        <= '0;
         gy_ff        <= '0;
         hw_ff        <= WEIGHT_RST;
         pen_ff       <= PENALTY_RST;
         sweep_ff     <= '0;
         stamp_ff     <= '0;
         count_ff     <= '0;
         route_len_ff <= '0;
         sstate_ff    <= SS_IDLE;
         rsp_valid_ff <= 1'b0;
         cmpv_ff      <= 1'b0;
         scan_rd_ff   <= '0;
      end else begin
         gw_ff        <= gw_in;
         gh_ff        <= gh_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         gx_ff        <= gx_in;
         gy_ff        <= gy_in;
         hw_ff        <= hw_in;
         pen_ff       <= pen_in;
         sweep_ff     <= sweep_in;
         stamp_ff     <= stamp_in;
         count_ff     <= count_in;
         route_len_ff <= route_len_in;
         sstate_ff    <= sstate_in;
         rsp_valid_ff <= rsp_valid_in;
         cmpv_ff      <= cmpv_in;
         scan_rd_ff   <= scan_rd_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rsp_ff     <= rsp_in;
      res_ff     <= res_in;
      cmpi_ff    <= cmpi_in;
      sel_ff     <= sel_in;
      best_ff    <= best_in;
      cur_ff     <= cur_in;
      nb_ff      <= nb_in;
      walk_ff    <= walk_in;
      curg_ff    <= curg_in;
      base_g_ff  <= base_g_in;
      g_ff       <= g_in;
      par_src_ff <= par_src_in;
      chk_ff     <= chk_in;
      h_ff       <= h_in;
      prod_ff    <= prod_in;
      hg_ff      <= hg_in;
      dir_ff     <= dir_in;
      route_n_ff <= route_n_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_tile && load_ok) begin
         cost_mem[load_addr] <= item_ff.tile_cost;
         flag_mem[load_addr] <= {item_ff.tile_occupied, item_ff.tile_solid};
      end
      cost_q <= cost_mem[cell_raddr];
      flag_q <= flag_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= stamp_wdata;
      end
      stamp_q <= stamp_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.open_calc) begin
         par_mem[nb_ff] <= par_src_ff;
      end
      par_q <= par_mem[cell_raddr];
   end

   always_ff @(posedge clock) begin
      if (open_we) begin
         ocell_mem[open_waddr] <= open_wcell;
         og_mem[open_waddr]    <= open_wg;
         osc_mem[open_waddr]   <= open_wscore;
      end
      ocell_q <= ocell_mem[open_raddr];
      og_q    <= og_mem[open_raddr];
      osc_q   <= osc_mem[open_raddr];
   end

   always_ff @(posedge clock) begin
      if (cmd.route_wr) begin
         route_mem[route_n_ff[AW-1:0]] <= walk_ff;
      end
      route_q <= route_mem[path_raddr];
   end

   assign sts.clear_last = (sweep_ff == AW'(DEPTH - 1));
   assign sts.sstate     = sstate_ff;
   assign sts.count_zero = (count_ff == '0);
   assign sts.open_skip  = chk_ff && ((stamp_q == stamp_ff) || flag_q[0]);
   assign sts.scan_done  = (scan_rd_ff == count_ff) && !cmpv_ff;
   assign sts.is_goal    = (cx_ext == COORD_W'(gx_ff)) && (cy_ext == COORD_W'(gy_ff));
   assign sts.nb_ok      = nb_ok;
   assign sts.nb_last    = (dir_ff == DIR_BOTTOM);
   assign sts.route_end  = par_q[AW] || (route_n_ff == CNT_W'(NCELLS));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.op         = item_ff.op;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/grid_astar_path_search_top.sv =====
// Top level of the grid path search block.
// The block runs a Manhattan-heuristic best-first grid search, one item at a time, and holds
// each result in an output register so the next item is taken while it waits. After reset a
// clearing pass resets the visit stamps of all 2^(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) cells
// (4096 by default), during which no item is accepted. A step ends at once when the path was
// found before or there is no path. A search step scans the open list one entry per cycle,
// then checks the four neighbors of the chosen cell, skipping an in-grid neighbor that is
// already visited or solid and opening each other one; the step that closes the goal walks
// the parent store instead to write the path entries. A result waits in the block while the
// output register holds a stalled result. The open list and the parent store each have a
// single read port.
module grid_astar_path_search_top
   import gaps_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64,
   parameter int STAMP_BITS = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   cmd_type cmd;
   sts_type sts;

   gaps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gaps_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .STAMP_BITS (STAMP_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

// ===== rtl/core/gaps_checker.sv =====
// Port-level checker of the grid path search block and its bind to the top level.
module gaps_checker
   import gaps_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled request item holds its place and value.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("stalled request item changed");

   // A stalled result item holds its place and value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result item changed");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= RS_ENTRY))
      else $error("result status out of range");

   // Only a path read reports coordinates.
   a_coord_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != RS_ENTRY) |->
         (rsp_data.path_x == 6'd0) && (rsp_data.path_y == 6'd0))
      else $error("coordinates outside a path read");

   // No route is stored while searching or after a failed search.
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.status == RS_SEARCHING) || (rsp_data.status == RS_NOPATH)) |->
         (rsp_data.path_length == '0))
      else $error("route length set without a found path");

endmodule

bind grid_astar_path_search_top gaps_checker u_gaps_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
